// ----- design/ilt_pkg.sv -----
package ilt_pkg;

    // Operation codes carried on the action port; code 7 is spare
    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_READ   = 3'd1,
        ACT_FIND   = 3'd2,
        ACT_WRITE  = 3'd3,
        ACT_REMOVE = 3'd4,
        ACT_CLEAR  = 3'd5,
        ACT_COUNT  = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BOUNDS    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        FSM_IDLE  = 4'b0001,
        FSM_READ  = 4'b0010,
        FSM_FIND  = 4'b0100,
        FSM_SHIFT = 4'b1000
    } fsm_t;

    localparam int POS_W    = 6;
    localparam int ITEM_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

endpackage

// ----- design/indexed_list_table.sv -----
// Indexed list table: an ordered list of up to DEPTH item words held in one
// synchronous RAM, with a count register. Issue an operation by raising start
// while busy is low; the operation is transferred at that clock edge. Exactly
// one result follows for every operation: done is high for a single cycle and
// status, read_item, found_position and entry_count are valid in that cycle
// only. The receiver cannot stall the block, so capture the result when done
// is seen. Append, write, clear, report count and every rejected operation
// finish without leaving idle (a new operation may be issued at the very next edge).
// A read passes through the READ state for the registered RAM read. Find walks the
// list one entry per cycle through the RAM read port until a match or the
// last entry; an empty list is answered not found without a walk.
// Remove shifts later entries down one per cycle, each step a RAM read of
// entry i+1 and a write to entry i; removing the top entry shifts nothing.
// busy stays high while a read, find or remove is under way.
// Entries beyond the count are never read, so the RAM needs no clearing pass
// after reset and clear only resets the count.
module indexed_list_table #(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [2:0]  action,
    input  logic [5:0]  position,
    input  logic [31:0] item_value,
    output logic [1:0]  status,
    output logic [31:0] read_item,
    output logic [5:0]  found_position,
    output logic [6:0]  entry_count
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = CW + ilt_pkg::POS_W;
    localparam int CW1 = CW + 1;

    ilt_pkg::fsm_t    state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [ITEM_WIDTH-1:0] key_reg, key_next;
    logic             done_reg, done_next;
    ilt_pkg::status_t status_reg, status_next;
    logic [31:0]      rd_item_reg, rd_item_next;
    logic [5:0]       found_reg, found_next;

    // RAM ports
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [ITEM_WIDTH-1:0] wdata;
    logic [AW-1:0]         raddr;
    logic [ITEM_WIDTH-1:0] rdata;

    logic [63:0]           val_wide;
    logic [ITEM_WIDTH-1:0] val;
    logic [63:0]           rd_wide;
    logic                  accept;
    logic                  pos_oob;
    logic                  find_last;
    logic                  shift_more;

    ilt_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (we),
        .wr_addr (waddr),
        .wr_data (wdata),
        .rd_addr (raddr),
        .rd_data (rdata)
    );

    // Cut the incoming word to the stored width
    assign val_wide = 64'(item_value);
    assign val      = val_wide[ITEM_WIDTH-1:0];

    always_comb
    begin
        rd_wide = '0;
        rd_wide[ITEM_WIDTH-1:0] = rdata;
    end

    assign accept  = start && (state_reg == ilt_pkg::FSM_IDLE);
    assign pos_oob = PW'(position) >= PW'(cnt_reg);

    // Find: the word in rdata belongs to idx_reg; stop after the last entry
    assign find_last  = (CW1'(idx_reg) + CW1'(1)) == CW1'(cnt_reg);
    // Remove: another step is due while the next source index is below count
    assign shift_more = (CW1'(idx_reg) + CW1'(2)) < CW1'(cnt_reg);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        key_next     = key_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        rd_item_next = rd_item_reg;
        found_next   = found_reg;
        we           = 1'b0;
        waddr        = idx_reg;
        wdata        = rdata;
        raddr        = AW'(position);

        unique case (state_reg)
            ilt_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    // Default result: ok, no item, no index
                    status_next  = ilt_pkg::ST_OK;
                    rd_item_next = '0;
                    found_next   = '0;
                    key_next     = val;
                    unique case (ilt_pkg::action_t'(action))
                        ilt_pkg::ACT_APPEND:
                        begin
                            done_next = 1'b1;
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                status_next = ilt_pkg::ST_FULL;
                            end
                            else
                            begin
                                we       = 1'b1;
                                waddr    = AW'(cnt_reg);
                                wdata    = val;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        ilt_pkg::ACT_READ:
                        begin
                            if (pos_oob)
                            begin
                                done_next   = 1'b1;
                                status_next = ilt_pkg::ST_BOUNDS;
                            end
                            else
                            begin
                                raddr      = AW'(position);
                                state_next = ilt_pkg::FSM_READ;
                            end
                        end
                        ilt_pkg::ACT_FIND:
                        begin
                            if (cnt_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ilt_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                raddr      = '0;
                                idx_next   = '0;
                                state_next = ilt_pkg::FSM_FIND;
                            end
                        end
                        ilt_pkg::ACT_WRITE:
                        begin
                            done_next = 1'b1;
                            if (pos_oob)
                            begin
                                status_next = ilt_pkg::ST_BOUNDS;
                            end
                            else
                            begin
                                we    = 1'b1;
                                waddr = AW'(position);
                                wdata = val;
                            end
                        end
                        ilt_pkg::ACT_REMOVE:
                        begin
                            if (pos_oob)
                            begin
                                done_next   = 1'b1;
                                status_next = ilt_pkg::ST_BOUNDS;
                            end
                            else if ((PW'(position) + PW'(1)) == PW'(cnt_reg))
                            begin
                                // Removing the top entry: nothing to shift
                                done_next = 1'b1;
                                cnt_next  = cnt_reg - CW'(1);
                            end
                            else
                            begin
                                idx_next   = AW'(position);
                                raddr      = AW'(position) + AW'(1);
                                state_next = ilt_pkg::FSM_SHIFT;
                            end
                        end
                        ilt_pkg::ACT_CLEAR:
                        begin
                            done_next = 1'b1;
                            cnt_next  = '0;
                        end
                        ilt_pkg::ACT_COUNT:
                        begin
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            // Spare code: report the count
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ilt_pkg::FSM_READ:
            begin
                rd_item_next = rd_wide[31:0];
                done_next    = 1'b1;
                state_next   = ilt_pkg::FSM_IDLE;
            end
            ilt_pkg::FSM_FIND:
            begin
                raddr = idx_reg + AW'(1);
                if (rdata == key_reg)
                begin
                    found_next  = 6'(idx_reg);
                    done_next   = 1'b1;
                    state_next  = ilt_pkg::FSM_IDLE;
                end
                else if (find_last)
                begin
                    status_next = ilt_pkg::ST_NOT_FOUND;
                    done_next   = 1'b1;
                    state_next  = ilt_pkg::FSM_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ilt_pkg::FSM_SHIFT:
            begin
                // Move entry idx+1 down into idx
                we    = 1'b1;
                waddr = idx_reg;
                wdata = rdata;
                raddr = idx_reg + AW'(2);
                if (shift_more)
                begin
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    done_next  = 1'b1;
                    state_next = ilt_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = ilt_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ilt_pkg::FSM_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Result and walk registers: no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        rd_item_reg <= rd_item_next;
        found_reg   <= found_next;
    end

    assign busy           = (state_reg != ilt_pkg::FSM_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign read_item      = rd_item_reg;
    assign found_position = found_reg;
    assign entry_count    = 7'(cnt_reg);

endmodule

// ----- design/ilt_ram.sv -----
module ilt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- tb/indexed_list_table_test.sv -----
module indexed_list_table_test;

    localparam int DEPTH         = 64;
    // Stop the run well past the slowest legal run
    localparam int LIMIT_CYCLES  = 500000;
    // Room for the longest remove shift and a margin at the end
    localparam int SETTLE_CYCLES = DEPTH + 8;
    // Cap the mismatch lines so a badly broken block cannot flood the log
    localparam int REPORT_CAP    = 200;
    // The spare action code behaves as report count
    localparam logic [2:0] ACT_SPARE = 3'd7;

    // Bias of one stretch of random traffic
    typedef enum int {
        BIAS_GROW,
        BIAS_SHRINK,
        BIAS_MIXED
    } bias_t;

    // One expected result, field for field as on the result ports
    typedef struct {
        ilt_pkg::status_t                  status;
        logic [ilt_pkg::ITEM_W-1:0]        read_item;
        logic [ilt_pkg::POS_W-1:0]         found_position;
        logic [ilt_pkg::COUNT_W-1:0]       entry_count;
    } list_result_t;

    logic                              clk;
    logic                              rst_n      = 1'b0;
    logic                              start      = 1'b0;
    logic [2:0]                        action     = '0;
    logic [ilt_pkg::POS_W-1:0]         position   = '0;
    logic [ilt_pkg::ITEM_W-1:0]        item_value = '0;
    logic                              busy;
    logic                              done;
    logic [ilt_pkg::STATUS_W-1:0]      status;
    logic [ilt_pkg::ITEM_W-1:0]        read_item;
    logic [ilt_pkg::POS_W-1:0]         found_position;
    logic [ilt_pkg::COUNT_W-1:0]       entry_count;

    // Shadow copy of the list, advanced at every accepted transfer
    logic [ilt_pkg::ITEM_W-1:0]        list_words [DEPTH];
    int unsigned                       list_len = 0;

    // Results still owed by the block, oldest first
    list_result_t                      pending_results [$];

    int unsigned                       error_count   = 0;
    int unsigned                       cycle_count   = 0;
    int unsigned                       send_idle_pct = 20;

    indexed_list_table #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ilt_pkg::ITEM_W)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .action         (action),
        .position       (position),
        .item_value     (item_value),
        .status         (status),
        .read_item      (read_item),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: give up once the run has gone on far too long
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("** indexed_list_table: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= REPORT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    // Apply one operation to the shadow list and return the result it owes.
    // Only entries below the count are ever looked at, so words that were
    // never written are never read.
    function automatic list_result_t apply_list_op(
        input logic [2:0]                 op,
        input logic [ilt_pkg::POS_W-1:0]  pos,
        input logic [ilt_pkg::ITEM_W-1:0] word);
        list_result_t r;
        int unsigned  i;
        int unsigned  pos_i;
        pos_i            = 32'(pos);
        r.status         = ilt_pkg::ST_OK;
        r.read_item      = '0;
        r.found_position = '0;
        case (op)
            ilt_pkg::ACT_APPEND:
                if (list_len >= DEPTH)
                    r.status = ilt_pkg::ST_FULL;
                else
                begin
                    list_words[list_len[ilt_pkg::POS_W-1:0]] = word;
                    list_len++;
                end
            ilt_pkg::ACT_READ:
                if (pos_i >= list_len)
                    r.status = ilt_pkg::ST_BOUNDS;
                else
                    r.read_item = list_words[pos];
            ilt_pkg::ACT_FIND:
            begin
                r.status = ilt_pkg::ST_NOT_FOUND;
                for (i = 0; i < list_len; i++)
                    if (list_words[i[ilt_pkg::POS_W-1:0]] == word)
                    begin
                        r.status         = ilt_pkg::ST_OK;
                        r.found_position = i[ilt_pkg::POS_W-1:0];
                        break;
                    end
            end
            ilt_pkg::ACT_WRITE:
                if (pos_i >= list_len)
                    r.status = ilt_pkg::ST_BOUNDS;
                else
                    list_words[pos] = word;
            ilt_pkg::ACT_REMOVE:
                if (pos_i >= list_len)
                    r.status = ilt_pkg::ST_BOUNDS;
                else
                begin
                    // shift the tail down one place and drop the top word
                    for (i = pos_i; i + 1 < list_len; i++)
                        list_words[i[ilt_pkg::POS_W-1:0]] =
                            list_words[ilt_pkg::POS_W'(i + 1)];
                    list_words[ilt_pkg::POS_W'(list_len - 1)] = '0;
                    list_len--;
                end
            ilt_pkg::ACT_CLEAR:
                list_len = 0;
            default:
                ;   // report count and the spare code change nothing
        endcase
        r.entry_count = list_len[ilt_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // Send one operation. Idle first at the current rate, then hold start
    // and the fields until the block has taken the transfer and dropped busy, and book the
    // result it owes. start is left high so a following transfer can go back to back.
    task automatic send_op(input logic [2:0]                 op,
                           input logic [ilt_pkg::POS_W-1:0]  pos,
                           input logic [ilt_pkg::ITEM_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        action     <= op;
        position   <= pos;
        item_value <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_list_op(op, pos, word));
    endtask

    // Result checker: each done pulse must match the oldest booked result
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with nothing pending: status %0d count %0d",
                                          status, entry_count));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              status, want.status));
                if (read_item !== want.read_item)
                    report_mismatch($sformatf("read_item %08h, wanted %08h",
                                              read_item, want.read_item));
                if (found_position !== want.found_position)
                    report_mismatch($sformatf("found_position %0d, wanted %0d",
                                              found_position, want.found_position));
                if (entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count %0d, wanted %0d",
                                              entry_count, want.entry_count));
            end
        end
    end

    // Hold the sender off until every booked result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Every operation but append and clear on an empty list, the spare code included
    task automatic test_empty_list();
        send_op(ilt_pkg::ACT_COUNT,  '0,   '0);
        send_op(ilt_pkg::ACT_READ,   '0,   '0);
        send_op(ilt_pkg::ACT_WRITE,  '0,   32'hFFFF_FFFF);
        send_op(ilt_pkg::ACT_REMOVE, '0,   '0);
        send_op(ilt_pkg::ACT_FIND,   '0,   '0);
        send_op(ACT_SPARE,           6'h3F, 32'hFFFF_FFFF);
    endtask

    // Short list: reads at and past the end, first-match find with a
    // duplicate, a miss, write in and out of range, remove at both ends,
    // and clear hiding the kept words
    task automatic test_basic_ops();
        send_op(ilt_pkg::ACT_APPEND, '0,   32'h0000_0000);
        send_op(ilt_pkg::ACT_APPEND, '0,   32'hFFFF_FFFF);
        send_op(ilt_pkg::ACT_APPEND, '0,   32'hA5A5_A5A5);
        send_op(ilt_pkg::ACT_APPEND, '0,   32'hFFFF_FFFF);
        send_op(ilt_pkg::ACT_READ,   6'd0, '0);
        send_op(ilt_pkg::ACT_READ,   6'd3, '0);
        send_op(ilt_pkg::ACT_READ,   6'd4, '0);
        send_op(ilt_pkg::ACT_READ,   6'h3F, '0);
        send_op(ilt_pkg::ACT_FIND,   '0,   32'hFFFF_FFFF);
        send_op(ilt_pkg::ACT_FIND,   '0,   32'h1234_5678);
        send_op(ilt_pkg::ACT_WRITE,  6'd2, 32'h5A5A_5A5A);
        send_op(ilt_pkg::ACT_WRITE,  6'd4, 32'hDEAD_BEEF);
        send_op(ilt_pkg::ACT_REMOVE, 6'd0, '0);
        send_op(ilt_pkg::ACT_READ,   6'd0, '0);
        send_op(ilt_pkg::ACT_REMOVE, 6'd2, '0);
        send_op(ilt_pkg::ACT_REMOVE, 6'd3, '0);
        send_op(ilt_pkg::ACT_CLEAR,  '0,   '0);
        send_op(ilt_pkg::ACT_READ,   6'd0, '0);
        send_op(ilt_pkg::ACT_COUNT,  '0,   '0);
    endtask

    // Fill the list, push past full, then hit the top index and the
    // longest shift
    task automatic test_fill_to_full();
        logic [ilt_pkg::ITEM_W-1:0] top_word;
        while (list_len < DEPTH)
            send_op(ilt_pkg::ACT_APPEND, '0, $urandom());
        top_word = list_words[DEPTH - 1];
        send_op(ilt_pkg::ACT_APPEND, '0,    $urandom());
        send_op(ilt_pkg::ACT_APPEND, '0,    32'hFFFF_FFFF);
        send_op(ilt_pkg::ACT_READ,   6'h3F, '0);
        send_op(ilt_pkg::ACT_FIND,   '0,    top_word);
        send_op(ilt_pkg::ACT_WRITE,  6'h3F, 32'h0F0F_0F0F);
        send_op(ilt_pkg::ACT_REMOVE, 6'd0,  '0);
        send_op(ilt_pkg::ACT_READ,   6'h3F, '0);
        send_op(ilt_pkg::ACT_APPEND, '0,    32'hF0F0_F0F0);
        send_op(ilt_pkg::ACT_FIND,   '0,    32'hF0F0_F0F0);
    endtask

    function automatic logic [2:0] pick_action(input bias_t bias);
        int unsigned roll;
        roll = $urandom_range(99);
        case (bias)
            BIAS_GROW:
                if      (roll < 62) return ilt_pkg::ACT_APPEND;
                else if (roll < 71) return ilt_pkg::ACT_READ;
                else if (roll < 80) return ilt_pkg::ACT_FIND;
                else if (roll < 87) return ilt_pkg::ACT_WRITE;
                else if (roll < 93) return ilt_pkg::ACT_REMOVE;
                else if (roll < 94) return ilt_pkg::ACT_CLEAR;
                else if (roll < 98) return ilt_pkg::ACT_COUNT;
                else                return ACT_SPARE;
            BIAS_SHRINK:
                if      (roll < 10) return ilt_pkg::ACT_APPEND;
                else if (roll < 25) return ilt_pkg::ACT_READ;
                else if (roll < 40) return ilt_pkg::ACT_FIND;
                else if (roll < 52) return ilt_pkg::ACT_WRITE;
                else if (roll < 92) return ilt_pkg::ACT_REMOVE;
                else if (roll < 94) return ilt_pkg::ACT_CLEAR;
                else if (roll < 98) return ilt_pkg::ACT_COUNT;
                else                return ACT_SPARE;
            default:
                if      (roll < 30) return ilt_pkg::ACT_APPEND;
                else if (roll < 45) return ilt_pkg::ACT_READ;
                else if (roll < 60) return ilt_pkg::ACT_FIND;
                else if (roll < 72) return ilt_pkg::ACT_WRITE;
                else if (roll < 88) return ilt_pkg::ACT_REMOVE;
                else if (roll < 91) return ilt_pkg::ACT_CLEAR;
                else if (roll < 97) return ilt_pkg::ACT_COUNT;
                else                return ACT_SPARE;
        endcase
    endfunction

    // Random traffic in stretches that grow, shrink or churn the list.
    // Positions mostly land inside the list, values often repeat or match
    // a live entry so finds hit and first-match ordering matters.
    task automatic test_random_ops(input int unsigned n_ops, input int unsigned idle_pct);
        bias_t                      bias;
        logic [2:0]                 op;
        logic [ilt_pkg::POS_W-1:0]  pos;
        logic [ilt_pkg::ITEM_W-1:0] word;
        int unsigned                n;
        send_idle_pct = idle_pct;
        bias = BIAS_MIXED;
        for (n = 0; n < n_ops; n++)
        begin
            if (n % 80 == 0)
                bias = bias_t'($urandom_range(2));
            op = pick_action(bias);
            if (list_len > 0 && $urandom_range(99) < 80)
                pos = ilt_pkg::POS_W'($urandom_range(list_len - 1));
            else
                pos = ilt_pkg::POS_W'($urandom_range(DEPTH - 1));
            if (op == ilt_pkg::ACT_FIND && list_len > 0 && $urandom_range(99) < 60)
                word = list_words[ilt_pkg::POS_W'($urandom_range(list_len - 1))];
            else if ($urandom_range(99) < 25)
                case ($urandom_range(3))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = $urandom_range(3);
                endcase
            else
                word = $urandom();
            send_op(op, pos, word);
        end
    endtask

    // Drop start, wait for the last result, allow for a trailing shift,
    // then give the verdict
    task automatic finish_run();
        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("** indexed_list_table: PASSED **");
        else
            $display("** indexed_list_table: FAILED **");
        $finish;
    endtask

    initial
    begin
        // Hold reset low, then release it on a clock edge
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        test_empty_list();
        test_basic_ops();
        test_fill_to_full();

        test_random_ops(400, 20);
        drain_results();
        test_random_ops(400, 77);
        drain_results();
        test_random_ops(400, 0);

        finish_run();
    end

endmodule
